### rtl/core/nnua_pkg.sv
// Shared types, codes and row-address helpers for the NNUE accumulator update block.
package nnua_pkg;

    localparam int WORD_W      = 16;
    localparam int ROW_W       = 10;
    localparam int WEIGHT_ROWS = 768;

    localparam logic [3:0] PIECE_CODES  = 4'd12;
    localparam logic [3:0] COLOR_PIECES = 4'd6;
    localparam logic [5:0] MIRROR_MASK  = 6'd56;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_UPDATE,
        ST_DRAIN,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [3:0]         piece_code;
        logic [5:0]         square;
        logic [8:0]         element_index;
        logic signed [15:0] weight_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] read_value;
        logic               applied;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic clr_we;
        logic wb_en;
        logic subtract;
        logic wt_we;
        logic done;
        logic applied;
        logic rd;
    } t_ctrl;

    function automatic logic [ROW_W-1:0] white_row(input logic [3:0] piece,
                                                   input logic [5:0] sq);
        return {piece, sq};
    endfunction

    // Colour-swapped piece on the vertically mirrored square
    function automatic logic [ROW_W-1:0] black_row(input logic [3:0] piece,
                                                   input logic [5:0] sq);
        logic [3:0] bp;
        bp = (piece < COLOR_PIECES) ? piece + COLOR_PIECES : piece - COLOR_PIECES;
        return {bp, sq ^ MIRROR_MASK};
    endfunction

endpackage

### rtl/core/nnua_ram.sv
// Generic RAM: one write port, two registered read ports.
module nnua_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/core/nnua_lane_alu.sv
// Shared lane adder/subtractor: one 16-bit wrapping add or subtract per lane.
module nnua_lane_alu #(
    parameter int WORDS = 16,
    localparam int VW = WORDS * nnua_pkg::WORD_W
) (
    input  logic [VW-1:0] i_acc,
    input  logic [VW-1:0] i_wt,
    input  logic          i_sub,
    output logic [VW-1:0] o_sum
);

    localparam int W = nnua_pkg::WORD_W;

    for (genvar g = 0; g < WORDS; g++) begin : g_lane
        assign o_sum[g*W +: W] = i_sub ? i_acc[g*W +: W] - i_wt[g*W +: W]
                                       : i_acc[g*W +: W] + i_wt[g*W +: W];
    end

endmodule

### rtl/core/nnua_seq.sv
// Command sequencer: decodes each item and steps the row counter over the accumulator.
module nnua_seq #(
    parameter int ACC_SIZE = 512,
    parameter int ROWS     = 32,
    localparam int KW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  nnua_pkg::t_in_item               i_item,
    output nnua_pkg::t_ctrl                  o_ctrl,
    output logic [KW-1:0]                    o_k,
    output logic [KW-1:0]                    o_wb_k,
    output logic [nnua_pkg::ROW_W-1:0]       o_row_white,
    output logic [nnua_pkg::ROW_W-1:0]       o_row_black
);

    localparam int HALF = ACC_SIZE / 2;

    nnua_pkg::t_state r_state, n_state;
    logic [KW-1:0]    r_k, n_k;
    logic [KW-1:0]    r_wb_k;
    logic             r_wb_en;
    logic             r_sub;
    logic [nnua_pkg::ROW_W-1:0] r_row_w, r_row_b;

    logic accept, piece_ok, wr_ok, rd_ok, last;

    assign accept   = i_start && (r_state == nnua_pkg::ST_IDLE);
    assign piece_ok = i_item.piece_code < nnua_pkg::PIECE_CODES;
    assign wr_ok    = piece_ok && (32'(i_item.element_index) < 32'(HALF));
    assign rd_ok    = 32'(i_item.element_index) < 32'(ACC_SIZE);
    assign last     = r_k == KW'(ROWS - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            nnua_pkg::ST_INIT, nnua_pkg::ST_CLEAR: begin
                if (last) n_state = nnua_pkg::ST_IDLE;
            end
            nnua_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (i_item.cmd) inside
                        nnua_pkg::CMD_CLEAR: n_state = nnua_pkg::ST_CLEAR;
                        nnua_pkg::CMD_ADD, nnua_pkg::CMD_REMOVE: begin
                            if (piece_ok) n_state = nnua_pkg::ST_UPDATE;
                        end
                        nnua_pkg::CMD_READ: begin
                            if (rd_ok) n_state = nnua_pkg::ST_READ;
                        end
                        default: n_state = nnua_pkg::ST_IDLE;
                    endcase
                end
            end
            nnua_pkg::ST_UPDATE: begin
                if (last) n_state = nnua_pkg::ST_DRAIN;
            end
            nnua_pkg::ST_DRAIN: n_state = nnua_pkg::ST_IDLE;
            nnua_pkg::ST_READ:  n_state = nnua_pkg::ST_IDLE;
            default:            n_state = nnua_pkg::ST_IDLE;
        endcase
    end

    // Advance through the rows in the sweep states, park at zero otherwise
    always_comb begin
        if (r_state == nnua_pkg::ST_INIT || r_state == nnua_pkg::ST_CLEAR ||
            r_state == nnua_pkg::ST_UPDATE) begin
            n_k = r_k + KW'(1);
        end else begin
            n_k = '0;
        end
    end

    always_comb begin
        o_ctrl          = '0;
        o_ctrl.busy     = r_state != nnua_pkg::ST_IDLE;
        o_ctrl.wb_en    = r_wb_en;
        o_ctrl.subtract = r_sub;
        o_ctrl.applied  = 1'b1;
        unique case (r_state)
            nnua_pkg::ST_INIT: begin
                o_ctrl.clr_we = 1'b1;
            end
            nnua_pkg::ST_CLEAR: begin
                o_ctrl.clr_we = 1'b1;
                o_ctrl.done   = last;
            end
            nnua_pkg::ST_IDLE: begin
                o_ctrl.wt_we   = accept && (i_item.cmd == nnua_pkg::CMD_WRITE) && wr_ok;
                o_ctrl.applied = o_ctrl.wt_we;
                // Commands that finish at once: writes and anything ignored
                o_ctrl.done    = accept &&
                    !((i_item.cmd == nnua_pkg::CMD_CLEAR) ||
                      (((i_item.cmd == nnua_pkg::CMD_ADD) ||
                        (i_item.cmd == nnua_pkg::CMD_REMOVE)) && piece_ok) ||
                      ((i_item.cmd == nnua_pkg::CMD_READ) && rd_ok));
            end
            nnua_pkg::ST_UPDATE: begin
                o_ctrl.done = 1'b0;
            end
            nnua_pkg::ST_DRAIN: begin
                o_ctrl.done = 1'b1;
            end
            nnua_pkg::ST_READ: begin
                o_ctrl.done = 1'b1;
                o_ctrl.rd   = 1'b1;
            end
            default: begin
                o_ctrl.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnua_pkg::ST_INIT;
            r_k     <= '0;
            r_wb_en <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_wb_en <= r_state == nnua_pkg::ST_UPDATE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_k <= r_k;
        if (accept) begin
            r_sub   <= i_item.cmd == nnua_pkg::CMD_REMOVE;
            r_row_w <= nnua_pkg::white_row(i_item.piece_code, i_item.square);
            r_row_b <= nnua_pkg::black_row(i_item.piece_code, i_item.square);
        end
    end

    assign o_k         = r_k;
    assign o_wb_k      = r_wb_k;
    assign o_row_white = r_row_w;
    assign o_row_black = r_row_b;

endmodule

### rtl/core/nnue_accumulator_update.sv
// Top level of the NNUE accumulator update block: weight RAM lanes, accumulator RAM, lane unit.
//
// Two-perspective first-layer accumulator with its own weight memory. An item is taken when
// start is high and busy is low; every item gives exactly one result, shown on o_result for
// one cycle with o_valid high, and the receiver cannot hold it off. The accumulator is kept
// as rows of LANES entries of each half side by side, and one lane add/subtract unit updates
// one such row of both halves per cycle, so add and remove keep busy high while the rows are
// swept and then through a drain state for the last write-back; the result is registered and
// shown in the cycle after the drain state. Clear sweeps zeros over the same rows, and the
// same clearing pass runs after reset before the first item is taken. A read holds busy while
// the accumulator RAM answers; a weight write or an ignored command does not raise busy and
// answers in the next cycle. ACCUMULATOR_SIZE and LANES are powers of two; LANES above half
// the accumulator size is treated as half the size.
module nnue_accumulator_update #(
    parameter int ACCUMULATOR_SIZE = 512,
    parameter int LANES            = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  nnua_pkg::t_in_item    i_item,
    output logic                  busy,
    output logic                  o_valid,
    output nnua_pkg::t_out_item   o_result
);

    localparam int W      = nnua_pkg::WORD_W;
    localparam int HALF   = ACCUMULATOR_SIZE / 2;
    localparam int NL     = (LANES < HALF) ? LANES : HALF;
    localparam int ROWS   = HALF / NL;
    localparam int KW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WDEPTH = nnua_pkg::WEIGHT_ROWS * ROWS;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int AWORD  = 2 * NL * W;
    localparam int SW     = $clog2(2 * NL);

    nnua_pkg::t_ctrl             w_ctrl;
    logic [KW-1:0]               w_k, w_wb_k, w_rd_k;
    logic [nnua_pkg::ROW_W-1:0]  w_row_w, w_row_b;
    logic [WAW-1:0]              w_wt_waddr, w_wt_raddr_w, w_wt_raddr_b;
    logic [SW-1:0]               w_wt_lane, w_rd_sel;
    logic                        w_rd_half;
    logic [AWORD-1:0]            w_wt_vec, w_acc_a, w_acc_b, w_sum;

    logic [SW-1:0]               r_rd_sel;
    logic                        r_out_vld, n_out_vld;
    nnua_pkg::t_out_item         r_out, n_out;

    nnua_seq #(
        .ACC_SIZE (ACCUMULATOR_SIZE),
        .ROWS     (ROWS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .o_ctrl      (w_ctrl),
        .o_k         (w_k),
        .o_wb_k      (w_wb_k),
        .o_row_white (w_row_w),
        .o_row_black (w_row_b)
    );

    // Weight element i of a row sits in lane i mod NL, word row*ROWS + i/NL
    assign w_wt_waddr = WAW'(32'(nnua_pkg::white_row(i_item.piece_code, i_item.square)) * ROWS
                             + 32'(i_item.element_index) / NL);
    assign w_wt_lane  = SW'(32'(i_item.element_index) % NL);
    assign w_wt_raddr_w = WAW'(32'(w_row_w) * ROWS + 32'(w_k));
    assign w_wt_raddr_b = WAW'(32'(w_row_b) * ROWS + 32'(w_k));

    for (genvar l = 0; l < NL; l++) begin : g_wt
        nnua_ram #(
            .WIDTH (W),
            .DEPTH (WDEPTH)
        ) u_wt_ram (
            .i_clk     (i_clk),
            .i_we      (w_ctrl.wt_we && (w_wt_lane == SW'(l))),
            .i_waddr   (w_wt_waddr),
            .i_wdata   (i_item.weight_value),
            .i_raddr_a (w_wt_raddr_w),
            .o_rdata_a (w_wt_vec[l*W +: W]),
            .i_raddr_b (w_wt_raddr_b),
            .o_rdata_b (w_wt_vec[(NL+l)*W +: W])
        );
    end

    // Read command: pick the row of the entry and its word within the row
    assign w_rd_half = 32'(i_item.element_index) >= 32'(HALF);
    assign w_rd_k    = KW'((32'(i_item.element_index) % HALF) / NL);
    assign w_rd_sel  = SW'((w_rd_half ? 32'(NL) : 32'd0) + 32'(i_item.element_index) % NL);

    nnua_ram #(
        .WIDTH (AWORD),
        .DEPTH (ROWS)
    ) u_acc_ram (
        .i_clk     (i_clk),
        .i_we      (w_ctrl.clr_we || w_ctrl.wb_en),
        .i_waddr   (w_ctrl.clr_we ? w_k : w_wb_k),
        .i_wdata   (w_ctrl.clr_we ? '0 : w_sum),
        .i_raddr_a (w_k),
        .o_rdata_a (w_acc_a),
        .i_raddr_b (w_rd_k),
        .o_rdata_b (w_acc_b)
    );

    nnua_lane_alu #(
        .WORDS (2 * NL)
    ) u_alu (
        .i_acc (w_acc_a),
        .i_wt  (w_wt_vec),
        .i_sub (w_ctrl.subtract),
        .o_sum (w_sum)
    );

    always_comb begin
        n_out_vld        = w_ctrl.done;
        n_out.applied    = w_ctrl.applied;
        n_out.read_value = w_ctrl.rd ? w_acc_b[r_rd_sel*W +: W] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        // Hold the word select while the read is in flight
        if (!w_ctrl.busy) begin
            r_rd_sel <= w_rd_sel;
        end
    end

    assign busy     = w_ctrl.busy;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    a_write_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.cmd == nnua_pkg::CMD_WRITE)) |=> o_valid)
        else $error("weight write gave no result in the next cycle");

    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.applied) |-> (o_result.read_value == '0))
        else $error("ignored command returned a non-zero value");

    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_item.cmd == nnua_pkg::CMD_ADD) ||
                            (i_item.cmd == nnua_pkg::CMD_REMOVE)) &&
         (i_item.piece_code < nnua_pkg::PIECE_CODES)) |=> (busy && !o_valid))
        else $error("piece update did not hold busy");

    a_single_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.clr_we && w_ctrl.wb_en))
        else $error("clear sweep and write-back collide on the accumulator");

endmodule
